@@ sv/text_terminal_cursor_engine_top_defines.svh @@
// Assertion macros for the text terminal cursor engine.
// Depends on nothing; the asserting module supplies clk_i and rst_ni.
`ifndef TEXT_TERMINAL_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_TERMINAL_CURSOR_ENGINE_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define TT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define TT_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

@@ sv/tterm_pkg.sv @@
// Shared types and constants for the text terminal cursor engine.
// Depends on nothing.
package tterm_pkg;

  localparam int TEXT_COLUMNS = 80;
  localparam int TEXT_ROWS    = 25;
  localparam int TAB_STOP     = 8;
  localparam int CELL_COUNT   = TEXT_COLUMNS * TEXT_ROWS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CFG_IDX_W = 2;
  localparam int COLOR_W   = 4;

  localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
  localparam logic [7:0]  CHAR_RETURN  = 8'd13;
  localparam logic [7:0]  CHAR_TAB     = 8'd9;
  localparam logic [7:0]  CHAR_SPACE   = 8'h20;
  localparam logic [15:0] CELL_RESET   = 16'h0720;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FILL,
    ST_REPORT
  } state_e;

  typedef enum logic [1:0] {
    FILL_INIT,
    FILL_CLEAR,
    FILL_SCROLL
  } fill_e;

  typedef struct packed {
    op_e              op;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;
  } cmd_t;

  typedef struct packed {
    logic [15:0]      cell_value;
    logic [ROW_W-1:0] report_row;
    logic [COL_W-1:0] report_col;
  } rsp_t;

endpackage

@@ sv/text_terminal_cursor_engine_top.sv @@
// An accepted op steps from idle through exec to report, where done_o rises; an in-range read
// adds a read state and a scroll or a clear a fill state. The one-op-at-a-time sequencer passes
// through idle after each result word, so no new op is taken before the last is reported; fills
// write one cell per cycle. Uses tterm_pkg and text_terminal_cursor_engine_top_defines.svh.
// Reset: cursor and origin go to zero and colors to their reset values at once, then a pass
// writes every cell to an attribute-7 space with busy_o high; no stalls on done_o.
`include "text_terminal_cursor_engine_top_defines.svh"

module text_terminal_cursor_engine_top
  import tterm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  cmd_t                 cmd_i,
  output logic                 busy_o,
  output logic                 done_o,
  output rsp_t                 rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COLOR_W-1:0]   cfg_data_i
);

  localparam int SUM_W = ROW_W + 1;
  localparam int TCOL_W = COL_W + 1;

  logic [15:0] mem_q [CELL_COUNT];
  logic [15:0] rd_q;

  state_e             state_q, state_d;
  fill_e              fill_kind_q, fill_kind_d;
  cmd_t               cmd_q;
  logic [ROW_W-1:0]   line_q, line_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   top_q, top_d;
  logic [ADDR_W-1:0]  fill_addr_q, fill_addr_d;
  logic [ADDR_W-1:0]  fill_end_q, fill_end_d;
  logic [15:0]        fill_val_q, fill_val_d;
  logic [15:0]        cell_q, cell_d;
  logic [COLOR_W-1:0] fg_q, bg_q;

  logic               we, re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [15:0]        wdata;

  logic [7:0]         attr;
  logic [SUM_W-1:0]   cur_sum, rd_sum;
  logic [ROW_W-1:0]   cur_phys, rd_phys;
  logic [ADDR_W-1:0]  cur_addr, rd_addr, top_addr;
  logic [TCOL_W-1:0]  col_inc, col_tab, col_next;
  logic               wrap;
  logic               rd_in_range;

  assign attr        = {bg_q, fg_q};
  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q != ST_IDLE);
  assign done_o      = (state_q == ST_REPORT);

  assign rsp_o.cell_value = cell_q;
  assign rsp_o.report_row = line_q;
  assign rsp_o.report_col = col_q;

  // Map visible rows onto the ring of physical rows.
  assign cur_sum  = SUM_W'(top_q) + SUM_W'(line_q);
  assign cur_phys = (cur_sum >= SUM_W'(TEXT_ROWS)) ? ROW_W'(cur_sum - SUM_W'(TEXT_ROWS))
                                                    : ROW_W'(cur_sum);
  assign rd_sum   = SUM_W'(top_q) + SUM_W'(cmd_q.read_row);
  assign rd_phys  = (rd_sum >= SUM_W'(TEXT_ROWS)) ? ROW_W'(rd_sum - SUM_W'(TEXT_ROWS))
                                                   : ROW_W'(rd_sum);
  assign cur_addr = ADDR_W'(cur_phys) * ADDR_W'(TEXT_COLUMNS) + ADDR_W'(col_q);
  assign rd_addr  = ADDR_W'(rd_phys) * ADDR_W'(TEXT_COLUMNS) + ADDR_W'(cmd_q.read_col);
  assign top_addr = ADDR_W'(top_q) * ADDR_W'(TEXT_COLUMNS);

  assign rd_in_range = (cmd_q.read_row < ROW_W'(TEXT_ROWS)) &&
                       (cmd_q.read_col < COL_W'(TEXT_COLUMNS));

  assign col_inc = TCOL_W'(col_q) + TCOL_W'(1);
  assign col_tab = TCOL_W'(((col_q / TAB_STOP) + 1) * TAB_STOP);

  always_comb begin
    col_next = TCOL_W'(col_q);
    wrap     = 1'b0;
    case (cmd_q.char_code)
      CHAR_NEWLINE: wrap = 1'b1;
      CHAR_RETURN:  col_next = '0;
      CHAR_TAB: begin
        col_next = col_tab;
        wrap     = (col_tab >= TCOL_W'(TEXT_COLUMNS));
      end
      default: begin
        col_next = col_inc;
        wrap     = (col_inc >= TCOL_W'(TEXT_COLUMNS));
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FG_RESET;
      bg_q <= BG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_FG_COLOR) fg_q <= cfg_data_i;
      if (cfg_index_i == CFG_BG_COLOR) bg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      fill_kind_q <= FILL_INIT;
      line_q      <= '0;
      col_q       <= '0;
      top_q       <= '0;
      fill_addr_q <= '0;
      fill_end_q  <= ADDR_W'(CELL_COUNT - 1);
      fill_val_q  <= CELL_RESET;
      cell_q      <= '0;
    end else begin
      state_q     <= state_d;
      fill_kind_q <= fill_kind_d;
      line_q      <= line_d;
      col_q       <= col_d;
      top_q       <= top_d;
      fill_addr_q <= fill_addr_d;
      fill_end_q  <= fill_end_d;
      fill_val_q  <= fill_val_d;
      cell_q      <= cell_d;
    end
  end

  // Ops run one at a time, so a read never overlaps a pending write.
  always_comb begin
    state_d     = state_q;
    fill_kind_d = fill_kind_q;
    line_d      = line_q;
    col_d       = col_q;
    top_d       = top_q;
    fill_addr_d = fill_addr_q;
    fill_end_d  = fill_end_q;
    fill_val_d  = fill_val_q;
    cell_d      = cell_q;
    we          = 1'b0;
    waddr       = fill_addr_q;
    wdata       = fill_val_q;
    re          = 1'b0;
    raddr       = rd_addr;

    case (state_q)
      ST_INIT, ST_FILL: begin
        we = 1'b1;
        fill_addr_d = fill_addr_q + ADDR_W'(1);
        if (fill_addr_q == fill_end_q) begin
          state_d = ST_REPORT;
          case (fill_kind_q)
            FILL_INIT: state_d = ST_IDLE;
            FILL_CLEAR: begin
              top_d  = '0;
              line_d = '0;
              col_d  = '0;
            end
            FILL_SCROLL: begin
              top_d  = (top_q == ROW_W'(TEXT_ROWS - 1)) ? '0 : top_q + ROW_W'(1);
              line_d = ROW_W'(TEXT_ROWS - 1);
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end

      ST_EXEC: begin
        cell_d  = '0;
        state_d = ST_REPORT;
        case (cmd_q.op)
          OP_PUT: begin
            if (cmd_q.char_code != CHAR_NEWLINE && cmd_q.char_code != CHAR_RETURN &&
                cmd_q.char_code != CHAR_TAB) begin
              we    = 1'b1;
              waddr = cur_addr;
              wdata = {attr, cmd_q.char_code};
            end
            col_d = COL_W'(col_next);
            if (wrap) begin
              col_d = '0;
              if (line_q == ROW_W'(TEXT_ROWS - 1)) begin
                // Blank the old top row; it becomes the new bottom row.
                state_d     = ST_FILL;
                fill_kind_d = FILL_SCROLL;
                fill_addr_d = top_addr;
                fill_end_d  = top_addr + ADDR_W'(TEXT_COLUMNS - 1);
                fill_val_d  = {attr, CHAR_SPACE};
              end else begin
                line_d = line_q + ROW_W'(1);
              end
            end
          end
          OP_CLEAR: begin
            state_d     = ST_FILL;
            fill_kind_d = FILL_CLEAR;
            fill_addr_d = '0;
            fill_end_d  = ADDR_W'(CELL_COUNT - 1);
            fill_val_d  = {attr, CHAR_SPACE};
          end
          OP_READ: begin
            if (rd_in_range) begin
              re      = 1'b1;
              state_d = ST_READ;
            end
          end
          default: state_d = ST_REPORT;
        endcase
      end

      ST_READ: begin
        cell_d  = rd_q;
        state_d = ST_REPORT;
      end

      ST_REPORT: state_d = ST_IDLE;

      default: state_d = ST_IDLE;
    endcase
  end

  // Cell memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rd_q <= mem_q[raddr];
  end

  `TT_ASSERT_NEXT(a_single_done, done_o, !done_o, "result strobe held for two cycles")
  `TT_ASSERT(a_cursor_range, (line_q < ROW_W'(TEXT_ROWS)) && (col_q < COL_W'(TEXT_COLUMNS)),
             "cursor outside the screen")
  `TT_ASSERT(a_top_range, top_q < ROW_W'(TEXT_ROWS), "scroll origin outside the ring")
  `TT_ASSERT(a_fill_bound, (state_q != ST_FILL) || (fill_addr_q <= fill_end_q),
             "fill ran past its last cell")
  `TT_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted word left block idle")

endmodule
